FILE: hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Constants, operation codes and the pipeline item shared by all stages.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
	localparam int TOP_W     = NUM_W - DATA_W;
	localparam int DEN_W     = DATA_W + 1;
	localparam int DIV_CELLS = DATA_W;

	localparam logic [DATA_W-1:0] RAW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] RAW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_INC      = 4'd10,
		OP_DEC      = 4'd11,
		OP_TO_INT   = 4'd12,
		OP_FROM_INT = 4'd13
	} op_t;

	// res doubles as the quotient shift register for divides
	typedef struct packed {
		logic              is_div;
		logic              ovf;
		logic              flag;
		logic [DATA_W-1:0] res;
		logic [DEN_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [DATA_W-1:0] low;
	} item_t;

endpackage

FILE: hdl/fpa_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Operation and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpa_cmd_if;
	import fpa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [3:0]               operation;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;

	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

FILE: hdl/fpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Result value and compare flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpa_rsp_if;
	import fpa_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic                     compare_true;

	modport source (output valid, result_value, compare_true, input ready);
	modport sink   (input valid, result_value, compare_true, output ready);
endinterface

FILE: hdl/fpa_front.sv
// ----------------------------------------------------------------------------
// Front end
// Stage 1 registers operands and product; stage 2 forms simple results,
// rounds the product and sets up the divider.
// ----------------------------------------------------------------------------
module fpa_front (
	input  logic           clk,
	input  logic           arst_n,
	fpa_cmd_if.sink        cmd,
	output logic           out_valid,
	output fpa_pkg::item_t out_item,
	input  logic           out_ready
);
	import fpa_pkg::*;

	logic                     valid_s1;
	logic [3:0]               op_s1;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic                     en_s1;
	logic                     en_s2;
	item_t                    item_d;

	logic signed [DATA_W:0]     sum;
	logic signed [DATA_W:0]     diff;
	logic [2*DATA_W+1:0]        rnd;
	logic [DATA_W-1+FRAC_BITS:0] shl;
	logic [NUM_W-1:0]           num;
	logic [DEN_W-1:0]           den;

	assign en_s2     = !out_valid || out_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign cmd.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cmd.valid) begin
			op_s1   <= cmd.operation;
			a_s1    <= cmd.operand_a;
			b_s1    <= cmd.operand_b;
			prod_s1 <= cmd.operand_a * cmd.operand_b;
		end
	end

	always_comb begin
		sum  = {a_s1[DATA_W-1], a_s1} + {b_s1[DATA_W-1], b_s1};
		diff = {a_s1[DATA_W-1], a_s1} - {b_s1[DATA_W-1], b_s1};
		rnd  = (({2'b00, prod_s1} << 1) >> FRAC_BITS) + (2*DATA_W+2)'(1);
		rnd  = rnd >> 1;
		shl  = (DATA_W+FRAC_BITS)'(unsigned'(a_s1)) << FRAC_BITS;
		num  = (NUM_W'(unsigned'(a_s1)) << (FRAC_BITS + 1)) + NUM_W'(unsigned'(b_s1));
		den  = {b_s1, 1'b0};

		item_d        = '0;
		item_d.den    = den;
		item_d.rem    = DEN_W'(num[NUM_W-1:DATA_W]);
		item_d.low    = num[DATA_W-1:0];
		item_d.ovf    = DEN_W'(num[NUM_W-1:DATA_W]) >= den;

		case (op_s1)
			OP_ADD: begin
				item_d.res = sum[DATA_W] ? '0 : (sum[DATA_W-1] ? RAW_MAX : sum[DATA_W-1:0]);
			end
			OP_SUB: begin
				item_d.res = diff[DATA_W] ? '0 :
				             (diff[DATA_W-1] ? RAW_MAX : diff[DATA_W-1:0]);
			end
			OP_MUL: begin
				if (prod_s1[2*DATA_W-1] || prod_s1 == '0)
					item_d.res = '0;
				else if (rnd[2*DATA_W+1:DATA_W-1] != '0)
					item_d.res = RAW_MAX;
				else
					item_d.res = rnd[DATA_W-1:0];
			end
			OP_DIV: begin
				item_d.is_div = !(a_s1 <= 0 || b_s1 <= 0);
			end
			OP_GT: item_d.flag = a_s1 > b_s1;
			OP_LT: item_d.flag = a_s1 < b_s1;
			OP_GE: item_d.flag = a_s1 >= b_s1;
			OP_LE: item_d.flag = a_s1 <= b_s1;
			OP_EQ: item_d.flag = a_s1 == b_s1;
			OP_NE: item_d.flag = a_s1 != b_s1;
			OP_INC: begin
				item_d.res = (a_s1 == signed'(RAW_MAX)) ? RAW_MAX : a_s1 + 1;
			end
			OP_DEC: begin
				item_d.res = (a_s1 == signed'(RAW_MIN)) ? RAW_MIN : a_s1 - 1;
			end
			OP_TO_INT: item_d.res = a_s1 >>> FRAC_BITS;
			OP_FROM_INT: begin
				if (a_s1 <= 0)
					item_d.res = '0;
				else if (shl[DATA_W-1+FRAC_BITS:DATA_W-1] != '0)
					item_d.res = RAW_MAX;
				else
					item_d.res = shl[DATA_W-1:0];
			end
			default: item_d.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			out_item <= item_d;
		end
	end
endmodule

FILE: hdl/fpa_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit per cell; other items pass through.
// ----------------------------------------------------------------------------
module fpa_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  fpa_pkg::item_t in_item,
	output logic           in_ready,
	output logic           out_valid,
	output fpa_pkg::item_t out_item,
	input  logic           out_ready
);
	import fpa_pkg::*;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           qbit;
	item_t          nxt;

	assign in_ready = !out_valid || out_ready;

	always_comb begin
		trial = {in_item.rem, in_item.low[DATA_W-1]};
		diff  = trial - {1'b0, in_item.den};
		qbit  = trial >= {1'b0, in_item.den};
		nxt   = in_item;
		if (in_item.is_div) begin
			nxt.low = in_item.low << 1;
			nxt.rem = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nxt.res = {in_item.res[DATA_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_item <= nxt;
		end
	end
endmodule

FILE: hdl/fpa_back.sv
// ----------------------------------------------------------------------------
// Output stage
// Saturates the quotient and holds the response register.
// ----------------------------------------------------------------------------
module fpa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  fpa_pkg::item_t in_item,
	output logic           in_ready,
	fpa_rsp_if.source      rsp
);
	import fpa_pkg::*;

	logic              valid_q;
	logic [DATA_W-1:0] res_q;
	logic              flag_q;
	logic [DATA_W-1:0] res_d;

	assign in_ready = !valid_q || rsp.ready;

	always_comb begin
		res_d = in_item.res;
		if (in_item.is_div && (in_item.ovf || in_item.res[DATA_W-1]))
			res_d = RAW_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q  <= res_d;
			flag_q <= in_item.flag;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.result_value = res_q;
	assign rsp.compare_true = flag_q;
endmodule

FILE: hdl/fixed_point_alu_core.sv
// Pipeline: two front stages, 32 divider cells and one output register lie
// between command and response; every operation takes the same path.
// Throughput: one transaction per cycle while rsp.ready is high; each divider cell resolves one
// quotient bit and stalled stages fill bubbles independently.
// Reset: arst_n clears all valid flags asynchronously; no other state.
// ----------------------------------------------------------------------------
// Fixed-point ALU core
// Q24.8 arithmetic, compares and conversions in a pipelined cell chain.
// ----------------------------------------------------------------------------
module fixed_point_alu_core (
	input  logic      clk,
	input  logic      arst_n,
	fpa_cmd_if.sink   cmd,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	logic  valid [DIV_CELLS+1];
	item_t item  [DIV_CELLS+1];
	logic  ready [DIV_CELLS+1];

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.out_valid (valid[0]),
		.out_item  (item[0]),
		.out_ready (ready[0])
	);

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		fpa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid[i]),
			.in_item   (item[i]),
			.in_ready  (ready[i]),
			.out_valid (valid[i+1]),
			.out_item  (item[i+1]),
			.out_ready (ready[i+1])
		);
	end

	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid[DIV_CELLS]),
		.in_item  (item[DIV_CELLS]),
		.in_ready (ready[DIV_CELLS]),
		.rsp      (rsp)
	);
endmodule
